// ===== design/polynomial_taylor_shift_macros.svh =====
// Assertion macros shared by the polynomial Taylor shift checker.
`ifndef POLYNOMIAL_TAYLOR_SHIFT_MACROS_SVH
`define POLYNOMIAL_TAYLOR_SHIFT_MACROS_SVH

// Clocked property with asynchronous active-low reset masking.
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a property in the next.
`define PTS_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
    `PTS_ASSERT(lbl, clk, rst_n, (cond) |=> (nxt), msg)

`endif

// ===== design/pts_pkg.sv =====
// Types, constants and arithmetic helpers for the polynomial Taylor shift.
package pts_pkg;

    localparam int TERMS     = 4;
    localparam int QW        = 32;
    localparam int FRAC      = 16;
    localparam int STEP_LAT  = 4;
    localparam int MAG_W     = 34;
    localparam int HALF_W    = 18;
    localparam int IN_W      = QW * (TERMS + 2);
    localparam int OUT_W     = QW * TERMS;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    // Quotients beyond this magnitude saturate for every divisor used.
    localparam logic [MAG_W-1:0] MAG_CAP = 34'h2_0000_0000;

    // floor(x / 3) == (x * DIV3_RECIP) >> DIV3_SHIFT for any x below 2**19.
    localparam logic [18:0] DIV3_RECIP = 19'd174763;
    localparam int          DIV3_SHIFT = 19;

    typedef logic signed [QW-1:0] q_t;

    typedef struct packed {
        q_t [TERMS-1:0] coef;
        q_t             dlt;
    } pay_t;

    function automatic q_t sat33(input logic signed [QW:0] v);
        q_t res;
        if (v[QW] != v[QW-1]) begin
            res = v[QW] ? Q_MIN : Q_MAX;
        end else begin
            res = v[QW-1:0];
        end
        return res;
    endfunction

    function automatic q_t sat_add(input q_t a, input q_t b);
        logic signed [QW:0] sum;
        sum = {a[QW-1], a} + {b[QW-1], b};
        return sat33(sum);
    endfunction

    function automatic logic [HALF_W-1:0] div3(input logic [HALF_W-1:0] x);
        logic [36:0] prod;
        prod = 37'(x) * 37'(DIV3_RECIP);
        return prod[DIV3_SHIFT +: HALF_W];
    endfunction

    // Apply sign to a magnitude and clamp to the Q16.16 range.
    function automatic q_t sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        q_t res;
        if (mag[MAG_W-1:QW-1] != '0) begin
            res = neg ? Q_MIN : Q_MAX;
        end else if (neg) begin
            res = ~mag[QW-1:0] + 32'd1;
        end else begin
            res = mag[QW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/polynomial_taylor_shift.sv =====
// Top level: Taylor shift of a Q16.16 derivative vector to a new reference point.
//
//  Channel | Dir | Width | Beat contents
//  --------+-----+-------+--------------------------------------------------
//  s_      | in  | 192   | old/new reference, coefficients zero..three
//  m_      | out | 128   | shifted coefficients zero..three
//
//  One beat per cycle sustained while m_ accepts. The pipeline has
//  one input register, then four register stages per Horner step
//  (saturating add, 32x32 multiply, scale and high-half divide, low-half
//  divide and saturate), then one merge stage and the output register.
//  Reset clears all valid flags; payload registers carry no reset.
//  A stalled m_ side parks one result in a skid register and holds s_tready
//  low until it drains; the pipeline freezes meanwhile.
module polynomial_taylor_shift #(
    parameter int COEF_COUNT = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // old_reference, new_reference, coef_zero, coef_one, coef_two, coef_three
    input  logic [pts_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // shifted_zero, shifted_one, shifted_two, shifted_three
    output logic [pts_pkg::OUT_W-1:0]   m_tdata
);

    localparam int COEF_N = (COEF_COUNT > pts_pkg::TERMS) ? pts_pkg::TERMS :
                            (COEF_COUNT < 1) ? 1 : COEF_COUNT;
    localparam int NSTEP  = COEF_N - 1;
    localparam int NPOS   = pts_pkg::STEP_LAT * NSTEP + 1;

    logic                                   en;
    pts_pkg::pay_t                          pay_in;
    pts_pkg::pay_t                          pay_reg [NPOS];
    logic [NPOS-1:0]                        vld_reg;
    logic                                   res_vld_reg;
    pts_pkg::q_t [pts_pkg::TERMS-1:0]       res;
    pts_pkg::q_t                            lane_acc [pts_pkg::TERMS][NSTEP+1];
    pts_pkg::q_t [pts_pkg::TERMS-1:0]       lane_fin;

    pts_pkg::q_t [pts_pkg::TERMS-1:0]       out_reg;
    pts_pkg::q_t [pts_pkg::TERMS-1:0]       skid_reg;
    logic                                   out_vld_reg;
    logic                                   out_vld_next;
    logic                                   skid_vld_reg;
    logic                                   skid_vld_next;
    logic                                   out_free;

    // Advance the whole pipeline unless the skid register is occupied.
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // Unpack the beat and form the saturated reference offset.
    always_comb begin
        pay_in.dlt = pts_pkg::sat33({s_tdata[63], s_tdata[63:32]}
                                  - {s_tdata[31], s_tdata[31:0]});
        for (int k = 0; k < pts_pkg::TERMS; k++) begin
            pay_in.coef[k] = s_tdata[2*pts_pkg::QW + pts_pkg::QW*k +: pts_pkg::QW];
        end
    end

    // Payload delay line feeding each step position.
    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg[0] <= pay_in;
            for (int p = 1; p < NPOS; p++) begin
                pay_reg[p] <= pay_reg[p-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= NPOS'({vld_reg, s_tvalid});
            res_vld_reg <= vld_reg[NPOS-1];
        end
    end

    // Lanes: lane k evaluates shifted_k. All lanes run NSTEP step slots in
    // lockstep; step slot t divides by NSTEP-t in every lane. Lane k idles
    // (sum held at zero) for its first k slots, then consumes coefficients
    // from the top down.
    for (genvar k = 0; k < pts_pkg::TERMS; k++) begin : g_lane
        assign lane_acc[k][0] = '0;
        for (genvar t = 0; t < NSTEP; t++) begin : g_step
            if (k < COEF_N && t >= k) begin : g_live
                pts_step #(
                    .DIV (NSTEP - t)
                ) u_step (
                    .aclk    (aclk),
                    .en      (en),
                    .acc_in  (lane_acc[k][t]),
                    .coef_in (pay_reg[pts_pkg::STEP_LAT*t].coef[NSTEP - t + k]),
                    .dlt_in  (pay_reg[pts_pkg::STEP_LAT*t].dlt),
                    .acc_out (lane_acc[k][t+1])
                );
            end else begin : g_idle
                assign lane_acc[k][t+1] = '0;
            end
        end
        assign lane_fin[k] = lane_acc[k][NSTEP];
    end

    pts_merge #(
        .COEF_N (COEF_N)
    ) u_merge (
        .aclk    (aclk),
        .en      (en),
        .coef_in (pay_reg[NPOS-1].coef),
        .acc_in  (lane_fin),
        .res_out (res)
    );

    // Output register plus skid: a result arriving while the output is
    // stalled drops into the skid and blocks the pipeline next cycle.
    assign out_free = !out_vld_reg || m_tready;

    always_comb begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (skid_vld_reg) begin
            if (out_free) begin
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
        end else if (out_free) begin
            out_vld_next = res_vld_reg;
        end else if (res_vld_reg) begin
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (out_free) begin
                out_reg <= skid_reg;
            end
        end else if (out_free) begin
            out_reg <= res;
        end else begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== design/pts_step.sv =====
// One Horner step of a lane: saturating add, multiply, scale and divide.
module pts_step #(
    parameter int DIV = 1
) (
    input  logic          aclk,
    input  logic          en,
    input  pts_pkg::q_t   acc_in,
    input  pts_pkg::q_t   coef_in,
    input  pts_pkg::q_t   dlt_in,
    output pts_pkg::q_t   acc_out
);

    pts_pkg::q_t                   s_reg;
    pts_pkg::q_t                   dlt_reg;
    logic signed [2*pts_pkg::QW-1:0] prod_reg;
    logic signed [2*pts_pkg::QW-1:0] prod_next;
    logic                          neg_reg;
    logic [pts_pkg::HALF_W-1:0]    hi_reg;
    logic [pts_pkg::HALF_W-1:0]    hi_next;
    logic [1:0]                    rem_reg;
    logic [1:0]                    rem_next;
    logic [pts_pkg::FRAC-1:0]      lo_reg;
    logic [pts_pkg::FRAC-1:0]      lo_next;
    pts_pkg::q_t                   acc_reg;
    pts_pkg::q_t                   acc_next;

    logic [2*pts_pkg::QW-1:0]      pmag;
    logic [47:0]                   pshift;
    logic [pts_pkg::MAG_W-1:0]     clip;
    logic [pts_pkg::MAG_W-1:0]     quo;
    logic [pts_pkg::HALF_W-1:0]    rem_full;
    logic [pts_pkg::MAG_W-1:0]     qmag;

    assign prod_next = s_reg * dlt_reg;

    // Magnitude of the product, drop the fraction, clip, divide the high half.
    always_comb begin
        pmag     = prod_reg[2*pts_pkg::QW-1] ? 64'(-prod_reg) : 64'(prod_reg);
        pshift   = pmag[2*pts_pkg::QW-1:pts_pkg::FRAC];
        clip     = (pshift > 48'(pts_pkg::MAG_CAP)) ? pts_pkg::MAG_CAP
                                                    : pshift[pts_pkg::MAG_W-1:0];
        quo      = (DIV == 2) ? (clip >> 1) : clip;
        rem_full = '0;
        if (DIV == 3) begin
            hi_next  = pts_pkg::div3(clip[pts_pkg::MAG_W-1:pts_pkg::FRAC]);
            rem_full = clip[pts_pkg::MAG_W-1:pts_pkg::FRAC] - 18'(hi_next * 18'd3);
            rem_next = rem_full[1:0];
            lo_next  = clip[pts_pkg::FRAC-1:0];
        end else begin
            hi_next  = quo[pts_pkg::MAG_W-1:pts_pkg::FRAC];
            rem_next = 2'b00;
            lo_next  = quo[pts_pkg::FRAC-1:0];
        end
    end

    // Finish the low half and saturate.
    always_comb begin
        if (DIV == 3) begin
            qmag = {hi_reg, {pts_pkg::FRAC{1'b0}}}
                 + {16'b0, pts_pkg::div3({rem_reg, lo_reg})};
        end else begin
            qmag = {hi_reg, lo_reg};
        end
        acc_next = pts_pkg::sat_mag(neg_reg, qmag);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg    <= pts_pkg::sat_add(acc_in, coef_in);
            dlt_reg  <= dlt_in;
            prod_reg <= prod_next;
            neg_reg  <= prod_reg[2*pts_pkg::QW-1];
            hi_reg   <= hi_next;
            rem_reg  <= rem_next;
            lo_reg   <= lo_next;
            acc_reg  <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

// ===== design/pts_merge.sv =====
// Merge stage: add each lane's Horner sum to its own coefficient.
module pts_merge #(
    parameter int COEF_N = 4
) (
    input  logic                                  aclk,
    input  logic                                  en,
    input  pts_pkg::q_t [pts_pkg::TERMS-1:0]      coef_in,
    input  pts_pkg::q_t [pts_pkg::TERMS-1:0]      acc_in,
    output pts_pkg::q_t [pts_pkg::TERMS-1:0]      res_out
);

    pts_pkg::q_t [pts_pkg::TERMS-1:0] res_reg;
    pts_pkg::q_t [pts_pkg::TERMS-1:0] res_next;

    always_comb begin
        for (int k = 0; k < pts_pkg::TERMS; k++) begin
            res_next[k] = (k < COEF_N) ? pts_pkg::sat_add(coef_in[k], acc_in[k]) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res_out = res_reg;

endmodule

// ===== design/pts_checker.sv =====
// Port-level checker for the polynomial Taylor shift, bound to the top level.
`include "polynomial_taylor_shift_macros.svh"

module pts_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [pts_pkg::OUT_W-1:0]   m_tdata
);

    `PTS_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
    `PTS_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata changed while stalled")
    `PTS_ASSERT_NEXT(a_ready_back, aclk, aresetn, m_tready, s_tready, "s_tready low after a cycle of m_tready")
    `PTS_ASSERT(a_stall_cause, aclk, aresetn, !s_tready |-> $past(m_tvalid && !m_tready), "s_tready low without an output stall")

endmodule

bind polynomial_taylor_shift pts_checker u_pts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/polynomial_taylor_shift_test.sv =====
// Self-checking testbench for the polynomial Taylor shift stream block.
module polynomial_taylor_shift_test;

    localparam int COEF_COUNT = 4;
    // Pipeline depth of the block, from input register to output register.
    localparam int LATENCY    = 4 * (COEF_COUNT - 1) + 3;
    localparam int PHASE_BEATS = 438;
    localparam int HOLD_CYCLES = 150;

    localparam int TERMS = pts_pkg::TERMS;
    localparam int QW    = pts_pkg::QW;
    localparam int IN_W  = pts_pkg::IN_W;
    localparam int OUT_W = pts_pkg::OUT_W;

    typedef pts_pkg::q_t q_t;

    localparam q_t Q_MAX = pts_pkg::Q_MAX;
    localparam q_t Q_MIN = pts_pkg::Q_MIN;

    // Predicts each shifted vector and checks results in arrival order.
    class shift_scoreboard;
        int               coef_count;
        int               fail_count;
        logic [OUT_W-1:0] expected_shifts[$];
        string            field_names[TERMS] =
            '{"shifted_zero", "shifted_one", "shifted_two", "shifted_three"};

        function new(int count);
            coef_count = count;
            fail_count = 0;
        endfunction

        function longint clamp_q(longint v);
            if (v > longint'(Q_MAX)) begin
                return longint'(Q_MAX);
            end
            if (v < longint'(Q_MIN)) begin
                return longint'(Q_MIN);
            end
            return v;
        endfunction

        // Rebase the derivative vector of one input beat to the new point.
        function logic [OUT_W-1:0] rebase_coefficients(logic [IN_W-1:0] beat);
            q_t               old_ref;
            q_t               new_ref;
            q_t               field;
            longint           coef[TERMS];
            longint           shifted;
            longint           delta;
            longint           acc;
            longint           sum;
            longint           quot;
            int               used;
            logic [OUT_W-1:0] vec;
            used    = coef_count > TERMS ? TERMS : (coef_count < 1 ? 1 : coef_count);
            old_ref = beat[0 +: QW];
            new_ref = beat[QW +: QW];
            delta   = clamp_q(longint'(new_ref) - longint'(old_ref));
            vec     = '0;
            for (int k = 0; k < TERMS; k++) begin
                field   = beat[QW * (k + 2) +: QW];
                coef[k] = (k < used) ? longint'(field) : 0;
            end
            for (int k = 0; k < used; k++) begin
                acc = 0;
                // Horner steps from the highest used term down to k+1.
                for (int j = used - 1; j > k; j--) begin
                    sum  = clamp_q(acc + coef[j]);
                    quot = (sum * delta) / 65536;
                    quot = quot / longint'(j - k);
                    acc  = clamp_q(quot);
                end
                shifted = clamp_q(coef[k] + acc);
                vec[QW * k +: QW] = shifted[QW-1:0];
            end
            return vec;
        endfunction

        function void note_input(logic [IN_W-1:0] beat);
            expected_shifts.push_back(rebase_coefficients(beat));
        endfunction

        function void check_result(logic [OUT_W-1:0] beat);
            logic [OUT_W-1:0] want;
            q_t               want_f;
            q_t               got_f;
            if (expected_shifts.size() == 0) begin
                $error("unexpected result beat %h", beat);
                fail_count++;
                return;
            end
            want = expected_shifts.pop_front();
            for (int k = 0; k < TERMS; k++) begin
                want_f = want[QW * k +: QW];
                got_f  = beat[QW * k +: QW];
                if (got_f !== want_f) begin
                    $error("%s mismatch: expected %0d, actual %0d",
                           field_names[k], want_f, got_f);
                    fail_count++;
                end
            end
        endfunction

        function int pending();
            return expected_shifts.size();
        endfunction
    endclass

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // old_reference, new_reference, coef_zero, coef_one, coef_two, coef_three
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // shifted_zero, shifted_one, shifted_two, shifted_three
    logic [OUT_W-1:0] m_tdata;

    shift_scoreboard  sb = new(COEF_COUNT);

    // Idling knobs, in percent per cycle, changed between phases.
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;

    polynomial_taylor_shift #(
        .COEF_COUNT (COEF_COUNT)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop in case the block wedges.
    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    // Sample both channels at the rising edge, before the block updates.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request that is
    // counted here so the sender keeps pushing while the block backs up.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [IN_W-1:0] pack_beat(q_t old_ref, q_t new_ref,
                                                  q_t c0, q_t c1, q_t c2, q_t c3);
        return {c3, c2, c1, c0, new_ref, old_ref};
    endfunction

    // Field value biased toward Q16.16 magnitudes that stay off the rails.
    function automatic q_t rand_field();
        q_t v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = int'($urandom_range(2097152)) - 1048576;
            7: begin
                case ($urandom_range(4))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = 32'sd0;
                    3: v = 32'sd1;
                    default: v = -32'sd1;
                endcase
            end
            default:    v = int'($urandom_range(33554432)) - 16777216;
        endcase
        return v;
    endfunction

    function automatic logic [IN_W-1:0] rand_beat();
        q_t old_ref;
        q_t new_ref;
        old_ref = rand_field();
        // Mostly a nearby new point, so derivatives do not all saturate.
        if ($urandom_range(9) < 7) begin
            new_ref = old_ref + (int'($urandom_range(2097152)) - 1048576);
        end else begin
            new_ref = rand_field();
        end
        return pack_beat(old_ref, new_ref, rand_field(), rand_field(),
                         rand_field(), rand_field());
    endfunction

    // Offer one beat; entered and left at a falling edge.
    task automatic send_beat(input logic [IN_W-1:0] beat);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    initial begin
        logic [IN_W-1:0] directed[$];
        int              phase_idle[4]  = '{0, 56, 0, 35};
        int              phase_stall[4] = '{0, 0, 56, 35};

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed beats: zero, identity shift, unit steps, saturated
        // distance both ways, overflow at every step, truncation of small
        // negatives, odd divisor with negative numerator, bit patterns.
        directed.push_back(pack_beat(0, 0, 0, 0, 0, 0));
        directed.push_back(pack_beat(32'sh0005_0000, 32'sh0005_0000,
                                     32'sh0001_0000, 32'sh0002_0000,
                                     32'sh0003_0000, 32'sh0004_0000));
        directed.push_back(pack_beat(0, 32'sh0001_0000, 32'sh0001_0000,
                                     32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000));
        directed.push_back(pack_beat(0, -32'sh0001_0000, 32'sh0001_0000,
                                     32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000));
        directed.push_back(pack_beat(Q_MIN, Q_MAX, 32'sh0000_0100, 32'sh0000_0200,
                                     32'sh0000_0300, 32'sh0000_0400));
        directed.push_back(pack_beat(Q_MAX, Q_MIN, 32'sh0000_0100, -32'sh0000_0200,
                                     32'sh0000_0300, -32'sh0000_0400));
        directed.push_back(pack_beat(0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        directed.push_back(pack_beat(0, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        directed.push_back(pack_beat(0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        directed.push_back(pack_beat(Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        directed.push_back(pack_beat(0, 32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
        directed.push_back(pack_beat(0, 32'sh0001_0000, 0, 0, 0, -32'sd5));
        directed.push_back(pack_beat(32'sh0010_0000, 32'sh000f_0000, 0, 32'sd7,
                                     -32'sd11, 32'sd13));
        directed.push_back(pack_beat(32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa,
                                     32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555));
        directed.push_back(pack_beat(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
                                     32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa));
        directed.push_back(pack_beat(0, -32'sh0064_0000, Q_MIN, 0, 0, Q_MAX));
        directed.push_back(pack_beat(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
        directed.push_back(pack_beat(0, 32'sd1, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        directed.push_back(pack_beat(-32'sh0003_0000, 32'sh0002_8000, -32'sh0001_0000,
                                     32'sh0000_8000, -32'sh0002_0000, 32'sh0003_0000));

        foreach (directed[i]) begin
            send_beat(directed[i]);
        end
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            // Back up the block: hold the result side while beats keep coming.
            if (ph == 0) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_BEATS; n++) begin
                send_beat(rand_beat());
            end
            // Pause the sender until every result is back.
            drain();
        end

        repeat (LATENCY + 8) @(posedge aclk);
        if (sb.fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
